### rtl/dcaa_pkg.sv
// Package for the dual-channel converter averager: payload widths, default
// parameter values and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package dcaa_pkg;

    // Fixed widths of the request and result fields
    localparam int DATA_W = 16;
    localparam int SKIP_W = 8;

    // Defaults for the top-level parameters
    localparam int RING_DEPTH_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_ADD0,
        ST_ADD1,
        ST_DIV0,
        ST_DIV1,
        ST_OUT
    } state_t;

endpackage

### rtl/dcaa_if.sv
// Valid/ready channel interfaces for the averager's request and result sides.
// Depends on dcaa_pkg for the field widths.
`timescale 1ns / 1ps

interface dcaa_in_if;
    import dcaa_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] sample;
    logic              skip_load;
    logic [SKIP_W-1:0] skip_count;

    modport source (output valid, output sample, output skip_load, output skip_count,
                    input ready);
    modport sink   (input valid, input sample, input skip_load, input skip_count,
                    output ready);
endinterface

interface dcaa_out_if;
    import dcaa_pkg::*;

    logic              valid;
    logic              ready;
    logic              next_channel;
    logic              sample_accepted;
    logic [DATA_W-1:0] last_ch0;
    logic [DATA_W-1:0] last_ch1;
    logic [DATA_W-1:0] avg_ch0;
    logic [DATA_W-1:0] avg_ch1;

    modport source (output valid, output next_channel, output sample_accepted,
                    output last_ch0, output last_ch1, output avg_ch0, output avg_ch1,
                    input ready);
    modport sink   (input valid, input next_channel, input sample_accepted,
                    input last_ch0, input last_ch1, input avg_ch0, input avg_ch1,
                    output ready);
endinterface

### rtl/dual_channel_adc_averager.sv
// Top level of the dual-channel converter averager: sequencer, skip logic and
// the shared accumulate unit. Depends on dcaa_pkg, dcaa_if and dcaa_ram.
`timescale 1ns / 1ps

// The block takes one conversion request at a time and returns exactly one
// result per request. After reset a clearing pass writes zero into every ring
// entry, one entry per cycle, so no request is taken until the pass is done. A
// request that does not finish a channel-1 sample at an even ring position is
// accepted, then loaded into the result register once that register is free.
// When the ring index lands on an even position, both ring means are
// recomputed by one shared adder that walks the two rings entry by entry, one
// channel per cycle. For a depth that is not a power of two each sum is then
// divided by a reciprocal multiplication that takes one 16-bit slice of the
// sum per cycle. A finished result waits in its register while the next
// request is accepted.
module dual_channel_adc_averager #(
    parameter int RING_DEPTH  = dcaa_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = dcaa_pkg::SAMPLE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    dcaa_in_if.sink   in_ch,
    dcaa_out_if.source out_ch
);
    import dcaa_pkg::*;

    localparam int  IDX_W    = $clog2(RING_DEPTH);
    localparam int  SUM_W    = SAMPLE_BITS + IDX_W;
    localparam int  CNT_W    = IDX_W;
    localparam bit  IS_POW2  = (RING_DEPTH == (1 << IDX_W));
    localparam int  MUL_W    = 16;
    localparam int  N_DIG    = (SUM_W + MUL_W - 1) / MUL_W;
    localparam int  PAD_W    = N_DIG * MUL_W;
    localparam int  PART_W   = MUL_W + SUM_W + 1;
    localparam int  PROD_W   = PAD_W + SUM_W + 1;
    localparam int  Q_LSB    = SUM_W + IDX_W;
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] SWEEP_END = CNT_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] DIV_END   = CNT_W'(N_DIG - 1);
    // Rounded-up reciprocal of the depth, exact for every sum of SUM_W bits
    localparam logic [SUM_W:0]   RECIP_M   =
        (SUM_W + 1)'(((64'd1 << Q_LSB) / 64'(RING_DEPTH)) + 64'd1);

    // Control and state registers
    state_t                 state_reg, state_next;
    logic                   ch_reg, ch_next;
    logic [SKIP_W-1:0]      skip_left_reg, skip_left_next;
    logic [IDX_W-1:0]       ring_index_reg, ring_index_next;
    logic                   acc_flag_reg, acc_flag_next;
    logic [SAMPLE_BITS-1:0] last0_reg, last0_next;
    logic [SAMPLE_BITS-1:0] last1_reg, last1_next;
    logic [SAMPLE_BITS-1:0] mean0_reg, mean0_next;
    logic [SAMPLE_BITS-1:0] mean1_reg, mean1_next;
    logic [SUM_W-1:0]       acc0_reg, acc0_next;
    logic [SUM_W-1:0]       acc1_reg, acc1_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    // Result register
    logic                   out_valid_reg;
    logic                   o_next_ch_reg;
    logic                   o_accepted_reg;
    logic [DATA_W-1:0]      o_last0_reg, o_last1_reg, o_avg0_reg, o_avg1_reg;
    logic                   out_load;

    // Datapath signals
    logic                   in_fire;
    logic [SAMPLE_BITS-1:0] samp_w;
    logic [SKIP_W-1:0]      skip_tmp, skip_dec;
    logic                   accepted_w;
    logic [IDX_W-1:0]       idx_inc;
    logic                   we0, we1, rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [SAMPLE_BITS-1:0] rdata0, rdata1;
    logic [SUM_W-1:0]       sum_out;
    logic [SUM_W-1:0]       div_src;
    logic [PAD_W-1:0]       div_pad;
    logic [MUL_W-1:0]       mul_digit;
    logic [PART_W-1:0]      mul_part;
    logic [PROD_W-1:0]      prod_step;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign samp_w  = SAMPLE_BITS'(in_ch.sample);

    // Skip countdown: optional load, then decrement while nonzero
    assign skip_tmp   = in_ch.skip_load ? in_ch.skip_count : skip_left_reg;
    assign skip_dec   = (skip_tmp != '0) ? skip_tmp - SKIP_W'(1) : skip_tmp;
    assign accepted_w = (skip_dec == '0);
    assign idx_inc    = (ring_index_reg == IDX_LAST) ? '0 : ring_index_reg + IDX_W'(1);

    // Write port shared by the clearing pass and the sample store
    assign ram_waddr = (state_reg == ST_CLR) ? cnt_reg : ring_index_reg;
    assign ram_wdata = (state_reg == ST_CLR) ? '0 : samp_w;

    // Ring storage, one memory per channel
    dcaa_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RING_DEPTH)) u_ring0 (
        .clk   (clk),
        .we    (we0),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata0)
    );

    dcaa_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RING_DEPTH)) u_ring1 (
        .clk   (clk),
        .we    (we1),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata1)
    );

    // Shared accumulate unit, channel 0 in ADD0 and channel 1 in ADD1
    assign sum_out = (state_reg == ST_ADD1) ? acc1_reg + SUM_W'(rdata1)
                                            : acc0_reg + SUM_W'(rdata0);

    // Division by the depth as a multiplication by its reciprocal, taking one
    // slice of the sum per cycle from the most significant slice down
    assign div_src   = (state_reg == ST_DIV1) ? acc1_reg : acc0_reg;
    assign div_pad   = PAD_W'(div_src);
    assign mul_digit = div_pad[(N_DIG - 1 - int'(cnt_reg)) * MUL_W +: MUL_W];
    assign mul_part  = PART_W'(mul_digit) * PART_W'(RECIP_M);
    assign prod_step = {prod_reg[PROD_W-MUL_W-1:0], {MUL_W{1'b0}}} + PROD_W'(mul_part);

    // Sequencer: next state and register updates
    always_comb
    begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        skip_left_next  = skip_left_reg;
        ring_index_next = ring_index_reg;
        acc_flag_next   = acc_flag_reg;
        last0_next      = last0_reg;
        last1_next      = last1_reg;
        mean0_next      = mean0_reg;
        mean1_next      = mean1_reg;
        acc0_next       = acc0_reg;
        acc1_next       = acc1_reg;
        prod_next       = prod_reg;
        cnt_next        = cnt_reg;
        in_ch.ready     = 1'b0;
        we0             = 1'b0;
        we1             = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = cnt_reg;
        out_load        = 1'b0;

        case (state_reg)
            ST_CLR:
            begin
                // Zero one entry of each ring per cycle after reset
                we0      = 1'b1;
                we1      = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == SWEEP_END)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    skip_left_next = skip_dec;
                    acc_flag_next  = accepted_w;
                    state_next     = ST_OUT;
                    if (!ch_reg)
                    begin
                        // Channel 0 always hands over to channel 1
                        if (accepted_w)
                        begin
                            we0        = 1'b1;
                            last0_next = samp_w;
                        end
                        ch_next = 1'b1;
                    end
                    else if (accepted_w)
                    begin
                        // Stored channel-1 sample closes the pair
                        we1             = 1'b1;
                        last1_next      = samp_w;
                        ch_next         = 1'b0;
                        ring_index_next = idx_inc;
                        if (!idx_inc[0])
                        begin
                            cnt_next   = '0;
                            state_next = ST_RD;
                        end
                    end
                end
            end

            ST_RD:
            begin
                rd_en      = 1'b1;
                acc0_next  = '0;
                acc1_next  = '0;
                state_next = ST_ADD0;
            end

            ST_ADD0:
            begin
                acc0_next  = sum_out;
                state_next = ST_ADD1;
            end

            ST_ADD1:
            begin
                acc1_next = sum_out;
                if (cnt_reg == SWEEP_END)
                begin
                    cnt_next  = '0;
                    prod_next = '0;
                    if (IS_POW2)
                    begin
                        mean0_next = acc0_reg[SUM_W-1:IDX_W];
                        mean1_next = sum_out[SUM_W-1:IDX_W];
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_DIV0;
                    end
                end
                else
                begin
                    // Fetch the next entry while this one is added
                    cnt_next   = cnt_reg + CNT_W'(1);
                    rd_en      = 1'b1;
                    rd_addr    = cnt_next;
                    state_next = ST_ADD0;
                end
            end

            ST_DIV0:
            begin
                prod_next = prod_step;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_END)
                begin
                    cnt_next   = '0;
                    prod_next  = '0;
                    mean0_next = prod_step[Q_LSB +: SAMPLE_BITS];
                    state_next = ST_DIV1;
                end
            end

            ST_DIV1:
            begin
                prod_next = prod_step;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_END)
                begin
                    cnt_next   = '0;
                    prod_next  = '0;
                    mean1_next = prod_step[Q_LSB +: SAMPLE_BITS];
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                // Hand the result over once the result register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            ch_reg         <= 1'b0;
            skip_left_reg  <= '0;
            ring_index_reg <= '0;
            acc_flag_reg   <= 1'b0;
            last0_reg      <= '0;
            last1_reg      <= '0;
            mean0_reg      <= '0;
            mean1_reg      <= '0;
            acc0_reg       <= '0;
            acc1_reg       <= '0;
            prod_reg       <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ch_reg         <= ch_next;
            skip_left_reg  <= skip_left_next;
            ring_index_reg <= ring_index_next;
            acc_flag_reg   <= acc_flag_next;
            last0_reg      <= last0_next;
            last1_reg      <= last1_next;
            mean0_reg      <= mean0_next;
            mean1_reg      <= mean1_next;
            acc0_reg       <= acc0_next;
            acc1_reg       <= acc1_next;
            prod_reg       <= prod_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            o_next_ch_reg  <= 1'b0;
            o_accepted_reg <= 1'b0;
            o_last0_reg    <= '0;
            o_last1_reg    <= '0;
            o_avg0_reg     <= '0;
            o_avg1_reg     <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                o_next_ch_reg  <= ch_reg;
                o_accepted_reg <= acc_flag_reg;
                o_last0_reg    <= DATA_W'(last0_reg);
                o_last1_reg    <= DATA_W'(last1_reg);
                o_avg0_reg     <= DATA_W'(mean0_reg);
                o_avg1_reg     <= DATA_W'(mean1_reg);
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.next_channel    = o_next_ch_reg;
    assign out_ch.sample_accepted = o_accepted_reg;
    assign out_ch.last_ch0        = o_last0_reg;
    assign out_ch.last_ch1        = o_last1_reg;
    assign out_ch.avg_ch0         = o_avg0_reg;
    assign out_ch.avg_ch1         = o_avg1_reg;

    // The block is busy in the cycle after it takes a request.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != ST_IDLE))
        else $error("sequencer idle right after a request was taken");

    // The stored flag agrees with the countdown left by the request.
    a_flag_matches_skip: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (acc_flag_reg == (skip_left_reg == '0)))
        else $error("accepted flag disagrees with skip countdown");

    // A dropped sample always leaves channel 1 as the next conversion.
    a_drop_goes_ch1: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.sample_accepted) |-> out_ch.next_channel)
        else $error("dropped sample did not select channel 1");

    // The ring index never runs past the last entry.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ring_index_reg <= IDX_LAST))
        else $error("ring index beyond ring depth");

    // The sweep counter stays inside the ring while summing.
    a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD0 || state_reg == ST_ADD1) |-> (cnt_reg <= SWEEP_END))
        else $error("sweep counter beyond ring depth");

endmodule

### rtl/dcaa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dcaa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
